// ===== hw/rtl/particle_integrate_and_bounce_defines.svh =====
// ----------------------------------------------------------------------------
// Particle integrate and bounce: assertion macros
// Shared concurrent assertion forms for the checker.
// ----------------------------------------------------------------------------
`ifndef PARTICLE_INTEGRATE_AND_BOUNCE_DEFINES_SVH
`define PARTICLE_INTEGRATE_AND_BOUNCE_DEFINES_SVH

// Same-cycle implication, disabled during reset
`define PIB_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled during reset
`define PIB_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== hw/rtl/pib_pkg.sv =====
// ----------------------------------------------------------------------------
// Particle integrate and bounce package
// Shared widths, register codes, fixed-point constants and helpers.
// ----------------------------------------------------------------------------
package pib_pkg;

  localparam int POS_W     = 32;
  localparam int LIFE_W    = 24;
  localparam int DT_W      = 16;
  localparam int DIM_W     = 16;
  localparam int CFG_IDX_W = 2;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_FIELD_WIDTH  = 2'd0,
    REG_FIELD_HEIGHT = 2'd1
  } pib_reg_t;

  localparam logic [DIM_W-1:0]  FIELD_W_RST    = 16'd1280;
  localparam logic [DIM_W-1:0]  FIELD_H_RST    = 16'd720;
  localparam logic [9:0]        GRAVITY_RAW    = 10'd980;
  localparam logic [15:0]       SHRINK_Q16     = 16'd64881;
  localparam logic [15:0]       BOUNCE_Q16     = 16'd26214;
  localparam logic [LIFE_W-1:0] LIFE_MIN_RAW   = 24'd65;
  localparam logic [LIFE_W-1:0] RADIUS_MIN_RAW = 24'd32768;
  localparam logic [15:0]       ROUND_HALF     = 16'h8000;

  // Item between the integrate and bounce sections
  typedef struct packed {
    logic signed [POS_W-1:0] pos_x;
    logic signed [POS_W-1:0] pos_y;
    logic signed [POS_W-1:0] vel_x;
    logic signed [POS_W-1:0] vel_y;
    logic [LIFE_W-1:0]       life;
    logic [LIFE_W-1:0]       radius;
    logic                    alive;
  } pib_mid_t;

  // Clamp a 34-bit signed value into the signed 32-bit range
  function automatic logic signed [POS_W-1:0] sat32(input logic signed [33:0] v);
    logic signed [33:0] max_v;
    logic signed [33:0] min_v;
    max_v = 34'sh0_7FFF_FFFF;
    min_v = -34'sh0_8000_0000;
    if (v > max_v) begin
      sat32 = max_v[POS_W-1:0];
    end else if (v < min_v) begin
      sat32 = min_v[POS_W-1:0];
    end else begin
      sat32 = v[POS_W-1:0];
    end
  endfunction

  // Round a 32x16 magnitude product back to Q16.16, ties up
  function automatic logic [POS_W-1:0] rnd_q16(input logic [47:0] p);
    logic [47:0] s;
    s = p + 48'(ROUND_HALF);
    rnd_q16 = s[47:16];
  endfunction

endpackage

// ===== hw/rtl/pib_integrate.sv =====
// ----------------------------------------------------------------------------
// Particle integrate section
// Two stages: products of velocity and step, gravity and radius shrink, and
// the lifetime decrement, then rounding, sums and saturation and the expiry test.
// ----------------------------------------------------------------------------
module pib_integrate (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             in_valid,
  output logic                             in_ready,
  input  logic signed [pib_pkg::POS_W-1:0] pos_x,
  input  logic signed [pib_pkg::POS_W-1:0] pos_y,
  input  logic signed [pib_pkg::POS_W-1:0] vel_x,
  input  logic signed [pib_pkg::POS_W-1:0] vel_y,
  input  logic [pib_pkg::LIFE_W-1:0]       life_left,
  input  logic [pib_pkg::LIFE_W-1:0]       radius,
  input  logic [pib_pkg::DT_W-1:0]         step_time,
  output logic                             mid_valid,
  input  logic                             mid_ready,
  output pib_pkg::pib_mid_t                mid
);
  import pib_pkg::*;

  // stage 1
  logic                    s1_valid;
  logic signed [POS_W-1:0] s1_pos_x;
  logic signed [POS_W-1:0] s1_pos_y;
  logic signed [POS_W-1:0] s1_vel_x;
  logic signed [POS_W-1:0] s1_vel_y;
  logic                    s1_dx_neg;
  logic                    s1_dy_neg;
  logic [47:0]             s1_dx_prod;
  logic [47:0]             s1_dy_prod;
  logic [25:0]             s1_grav;
  logic [LIFE_W-1:0]       s1_life;
  logic [39:0]             s1_rad_prod;

  logic                    s1_ready;
  logic [POS_W-1:0]        vx_mag;
  logic [POS_W-1:0]        vy_mag;
  logic [LIFE_W-1:0]       life_sub;

  logic [POS_W-1:0]        dx_mag;
  logic [POS_W-1:0]        dy_mag;
  logic signed [32:0]      dx_s;
  logic signed [32:0]      dy_s;
  logic signed [33:0]      px_sum;
  logic signed [33:0]      py_sum;
  logic signed [33:0]      vy_sum;
  logic [39:0]             rad_rnd;
  logic [LIFE_W-1:0]       nrad;
  pib_mid_t                mid_next;

  assign in_ready = !s1_valid || s1_ready;
  assign s1_ready = !mid_valid || mid_ready;

  assign vx_mag   = vel_x[POS_W-1] ? POS_W'(-vel_x) : POS_W'(vel_x);
  assign vy_mag   = vel_y[POS_W-1] ? POS_W'(-vel_y) : POS_W'(vel_y);
  assign life_sub = (life_left > LIFE_W'(step_time)) ? life_left - LIFE_W'(step_time)
                                                     : '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_ready) begin
      s1_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      s1_pos_x    <= pos_x;
      s1_pos_y    <= pos_y;
      s1_vel_x    <= vel_x;
      s1_vel_y    <= vel_y;
      s1_dx_neg   <= vel_x[POS_W-1];
      s1_dy_neg   <= vel_y[POS_W-1];
      s1_dx_prod  <= 48'(vx_mag) * 48'(step_time);
      s1_dy_prod  <= 48'(vy_mag) * 48'(step_time);
      s1_grav     <= 26'(GRAVITY_RAW) * 26'(step_time);
      s1_life     <= life_sub;
      s1_rad_prod <= 40'(radius) * 40'(SHRINK_Q16);
    end
  end

  // stage 2: round, restore sign, saturate
  always_comb begin
    dx_mag  = rnd_q16(s1_dx_prod);
    dy_mag  = rnd_q16(s1_dy_prod);
    dx_s    = s1_dx_neg ? -$signed({1'b0, dx_mag}) : $signed({1'b0, dx_mag});
    dy_s    = s1_dy_neg ? -$signed({1'b0, dy_mag}) : $signed({1'b0, dy_mag});
    px_sum  = 34'(s1_pos_x) + 34'(dx_s);
    py_sum  = 34'(s1_pos_y) + 34'(dy_s);
    vy_sum  = 34'(s1_vel_y) + $signed({8'b0, s1_grav});
    rad_rnd = s1_rad_prod + 40'(ROUND_HALF);
    nrad    = rad_rnd[39:16];

    mid_next.pos_x  = sat32(px_sum);
    mid_next.pos_y  = sat32(py_sum);
    mid_next.vel_x  = s1_vel_x;
    mid_next.vel_y  = sat32(vy_sum);
    mid_next.life   = s1_life;
    mid_next.radius = nrad;
    mid_next.alive  = (s1_life > LIFE_MIN_RAW) && (nrad >= RADIUS_MIN_RAW);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mid_valid <= 1'b0;
    end else if (s1_ready) begin
      mid_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_valid && s1_ready) begin
      mid <= mid_next;
    end
  end

endmodule

// ===== hw/rtl/pib_bounce.sv =====
// ----------------------------------------------------------------------------
// Particle bounce section
// Two stages: wall tests, clamp targets and bounce products, then
// rounding, negation and the output register.
// ----------------------------------------------------------------------------
module pib_bounce (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              mid_valid,
  output logic                              mid_ready,
  input  pib_pkg::pib_mid_t                 mid,
  input  logic [pib_pkg::DIM_W-1:0]         field_width,
  input  logic [pib_pkg::DIM_W-1:0]         field_height,
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic signed [pib_pkg::POS_W-1:0]  new_pos_x,
  output logic signed [pib_pkg::POS_W-1:0]  new_pos_y,
  output logic signed [pib_pkg::POS_W-1:0]  new_vel_x,
  output logic signed [pib_pkg::POS_W-1:0]  new_vel_y,
  output logic [pib_pkg::LIFE_W-1:0]        new_life,
  output logic [pib_pkg::LIFE_W-1:0]        new_radius,
  output logic                              alive,
  output logic                              hit_wall
);
  import pib_pkg::*;

  typedef struct packed {
    logic                    hit;
    logic signed [POS_W-1:0] pos;
  } axis_t;

  // Test one axis against its low and high wall
  function automatic axis_t clamp_axis(input logic signed [POS_W-1:0] pos,
                                       input logic [LIFE_W-1:0]       rad,
                                       input logic [DIM_W-1:0]        dim,
                                       input logic                    live);
    logic signed [33:0] p;
    logic signed [33:0] r;
    logic signed [33:0] lim;
    logic               lo;
    logic               hi;
    axis_t              res;
    p   = 34'(pos);
    r   = $signed({10'b0, rad});
    lim = $signed({2'b0, dim, 16'b0});
    lo  = (p - r) <= 34'sd0;
    hi  = (p + r) >= lim;
    res.hit = live && (lo || hi);
    if (!res.hit) begin
      res.pos = pos;
    end else if (lo) begin
      res.pos = sat32(r);
    end else begin
      res.pos = sat32(lim - r);
    end
    return res;
  endfunction

  // stage 3
  logic                    s3_valid;
  logic signed [POS_W-1:0] s3_pos_x;
  logic signed [POS_W-1:0] s3_pos_y;
  logic signed [POS_W-1:0] s3_vel_x;
  logic signed [POS_W-1:0] s3_vel_y;
  logic                    s3_hit_x;
  logic                    s3_hit_y;
  logic                    s3_vx_neg;
  logic                    s3_vy_neg;
  logic [47:0]             s3_vx_prod;
  logic [47:0]             s3_vy_prod;
  logic [LIFE_W-1:0]       s3_life;
  logic [LIFE_W-1:0]       s3_rad;
  logic                    s3_alive;

  logic                    s3_ready;
  logic                    out_ready;
  axis_t                   ax_x;
  axis_t                   ax_y;
  logic [POS_W-1:0]        vx_mag;
  logic [POS_W-1:0]        vy_mag;
  logic [POS_W-1:0]        bx_mag;
  logic [POS_W-1:0]        by_mag;
  logic [POS_W-1:0]        bx_val;
  logic [POS_W-1:0]        by_val;

  assign out_ready = !out_valid || !out_stall;
  assign s3_ready  = !s3_valid || out_ready;
  assign mid_ready = s3_ready;

  assign ax_x   = clamp_axis(mid.pos_x, mid.radius, field_width, mid.alive);
  assign ax_y   = clamp_axis(mid.pos_y, mid.radius, field_height, mid.alive);
  assign vx_mag = mid.vel_x[POS_W-1] ? POS_W'(-mid.vel_x) : POS_W'(mid.vel_x);
  assign vy_mag = mid.vel_y[POS_W-1] ? POS_W'(-mid.vel_y) : POS_W'(mid.vel_y);

  always_ff @(posedge clk) begin
    if (rst) begin
      s3_valid <= 1'b0;
    end else if (s3_ready) begin
      s3_valid <= mid_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (mid_valid && s3_ready) begin
      s3_pos_x   <= ax_x.pos;
      s3_pos_y   <= ax_y.pos;
      s3_vel_x   <= mid.vel_x;
      s3_vel_y   <= mid.vel_y;
      s3_hit_x   <= ax_x.hit;
      s3_hit_y   <= ax_y.hit;
      s3_vx_neg  <= mid.vel_x[POS_W-1];
      s3_vy_neg  <= mid.vel_y[POS_W-1];
      s3_vx_prod <= 48'(vx_mag) * 48'(BOUNCE_Q16);
      s3_vy_prod <= 48'(vy_mag) * 48'(BOUNCE_Q16);
      s3_life    <= mid.life;
      s3_rad     <= mid.radius;
      s3_alive   <= mid.alive;
    end
  end

  // stage 4: bounced velocity is minus the scaled velocity, so flip the sign
  always_comb begin
    bx_mag = rnd_q16(s3_vx_prod);
    by_mag = rnd_q16(s3_vy_prod);
    bx_val = s3_vx_neg ? bx_mag : -bx_mag;
    by_val = s3_vy_neg ? by_mag : -by_mag;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_ready) begin
      out_valid <= s3_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s3_valid && out_ready) begin
      new_pos_x  <= s3_pos_x;
      new_pos_y  <= s3_pos_y;
      new_vel_x  <= s3_hit_x ? $signed(bx_val) : s3_vel_x;
      new_vel_y  <= s3_hit_y ? $signed(by_val) : s3_vel_y;
      new_life   <= s3_life;
      new_radius <= s3_rad;
      alive      <= s3_alive;
      hit_wall   <= s3_hit_x || s3_hit_y;
    end
  end

endmodule

// ===== hw/rtl/particle_integrate_and_bounce.sv =====
// An accepted item passes the stage 1, mid, stage 3 and output registers in that order.
// Throughput: one item per cycle while out_stall is low; four register stages, each with its own valid.
// A stalled output holds its stage; bubbles upstream still close up behind it.
// Reset clears all stage valids and loads field_width 1280 and field_height 720.
// Configuration writes are taken in any cycle (cfg_ready is always high).
// ----------------------------------------------------------------------------
// Particle integrate and bounce
// Euler step with gravity, lifetime and radius decay, and wall bounce.
// ----------------------------------------------------------------------------
module particle_integrate_and_bounce (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 cfg_valid,
  output logic                                 cfg_ready,
  input  logic [pib_pkg::CFG_IDX_W-1:0]        cfg_index,
  input  logic [pib_pkg::DIM_W-1:0]            cfg_data,
  input  logic                                 in_valid,
  output logic                                 in_stall,
  input  logic signed [pib_pkg::POS_W-1:0]     pos_x,
  input  logic signed [pib_pkg::POS_W-1:0]     pos_y,
  input  logic signed [pib_pkg::POS_W-1:0]     vel_x,
  input  logic signed [pib_pkg::POS_W-1:0]     vel_y,
  input  logic [pib_pkg::LIFE_W-1:0]           life_left,
  input  logic [pib_pkg::LIFE_W-1:0]           radius,
  input  logic [pib_pkg::DT_W-1:0]             step_time,
  output logic                                 out_valid,
  input  logic                                 out_stall,
  output logic signed [pib_pkg::POS_W-1:0]     new_pos_x,
  output logic signed [pib_pkg::POS_W-1:0]     new_pos_y,
  output logic signed [pib_pkg::POS_W-1:0]     new_vel_x,
  output logic signed [pib_pkg::POS_W-1:0]     new_vel_y,
  output logic [pib_pkg::LIFE_W-1:0]           new_life,
  output logic [pib_pkg::LIFE_W-1:0]           new_radius,
  output logic                                 alive,
  output logic                                 hit_wall
);
  import pib_pkg::*;

  logic [DIM_W-1:0] field_width;
  logic [DIM_W-1:0] field_height;
  logic             in_ready;
  logic             mid_valid;
  logic             mid_ready;
  pib_mid_t         mid;

  assign cfg_ready = 1'b1;
  assign in_stall  = !in_ready;

  // Indexes beyond the register list are dropped
  always_ff @(posedge clk) begin
    if (rst) begin
      field_width  <= FIELD_W_RST;
      field_height <= FIELD_H_RST;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_FIELD_WIDTH:  field_width  <= cfg_data;
        REG_FIELD_HEIGHT: field_height <= cfg_data;
        default: ;
      endcase
    end
  end

  pib_integrate u_integrate (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .pos_x     (pos_x),
    .pos_y     (pos_y),
    .vel_x     (vel_x),
    .vel_y     (vel_y),
    .life_left (life_left),
    .radius    (radius),
    .step_time (step_time),
    .mid_valid (mid_valid),
    .mid_ready (mid_ready),
    .mid       (mid)
  );

  pib_bounce u_bounce (
    .clk          (clk),
    .rst          (rst),
    .mid_valid    (mid_valid),
    .mid_ready    (mid_ready),
    .mid          (mid),
    .field_width  (field_width),
    .field_height (field_height),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .new_pos_x    (new_pos_x),
    .new_pos_y    (new_pos_y),
    .new_vel_x    (new_vel_x),
    .new_vel_y    (new_vel_y),
    .new_life     (new_life),
    .new_radius   (new_radius),
    .alive        (alive),
    .hit_wall     (hit_wall)
  );

endmodule

// ===== hw/rtl/pib_checker.sv =====
// ----------------------------------------------------------------------------
// Particle integrate and bounce checker
// Port-level assertions, bound to the top level.
// ----------------------------------------------------------------------------
`include "particle_integrate_and_bounce_defines.svh"

module pib_port_checker (
  input logic                             clk,
  input logic                             rst,
  input logic                             out_valid,
  input logic                             out_stall,
  input logic signed [pib_pkg::POS_W-1:0] new_pos_x,
  input logic signed [pib_pkg::POS_W-1:0] new_vel_y,
  input logic [pib_pkg::LIFE_W-1:0]       new_life,
  input logic [pib_pkg::LIFE_W-1:0]       new_radius,
  input logic                             alive,
  input logic                             hit_wall
);
  import pib_pkg::*;

  `PIB_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid && $stable(new_pos_x) && $stable(new_vel_y), "stalled result changed")
  `PIB_ASSERT_NOW(a_dead_no_hit, out_valid && !alive, !hit_wall, "expired item reports a wall hit")
  `PIB_ASSERT_NOW(a_alive_bounds, out_valid && alive, (new_life > LIFE_MIN_RAW) && (new_radius >= RADIUS_MIN_RAW), "live item below expiry limits")
  `PIB_ASSERT_NOW(a_reset_empty, $past(rst), !out_valid, "result valid right after reset")

endmodule

bind particle_integrate_and_bounce pib_port_checker u_pib_checker (.*);
